>>> rtl/circular_list_with_cursor_top_macros.svh
// Assertion macros shared by the block; clocked on clk_i, disabled in reset.
`ifndef CIRCULAR_LIST_WITH_CURSOR_TOP_MACROS_SVH
`define CIRCULAR_LIST_WITH_CURSOR_TOP_MACROS_SVH

// Condition that holds at every edge.
`define CLWC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CLWC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/clwc_pkg.sv
`timescale 1ns / 1ps

package clwc_pkg;

  // Fixed field widths of the channels
  localparam int REQ_W   = 2;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CNT_O_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REM = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADV = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Main sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ADD2,
    SEQ_LINK,
    SEQ_VAL
  } seq_state_e;

  // Free-slot allocator
  typedef enum logic [1:0] {
    ALC_CLEAR,
    ALC_READY,
    ALC_SCAN
  } alloc_state_e;

  // Commands from the sequencer to the allocator
  typedef struct packed {
    logic take;     // claim the current lowest free slot
    logic rel;      // return a slot to the pool
    logic no_scan;  // take fills the store, skip the search
    logic was_full; // store was full before this release
  } alloc_cmd_t;

endpackage

>>> rtl/clwc_req_if.sv
`timescale 1ns / 1ps

interface clwc_req_if;
  logic                             valid;
  logic                             ready;
  logic [clwc_pkg::REQ_W-1:0]       req_type;
  logic [clwc_pkg::VAL_W-1:0]       value_in;

  modport source (output valid, output req_type, output value_in, input ready);
  modport sink   (input valid, input req_type, input value_in, output ready);
endinterface

>>> rtl/clwc_rsp_if.sv
`timescale 1ns / 1ps

interface clwc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [clwc_pkg::ST_W-1:0]        status;
  logic [clwc_pkg::VAL_W-1:0]       front_value;
  logic [clwc_pkg::VAL_W-1:0]       back_value;
  logic                             is_empty;
  logic [clwc_pkg::CNT_O_W-1:0]     entry_count;

  modport source (output valid, output status, output front_value, output back_value,
                  output is_empty, output entry_count, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input is_empty, input entry_count, output ready);
endinterface

>>> rtl/circular_list_with_cursor_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields
// req_i   | in  | req_type[1:0], value_in[31:0]
// rsp_o   | out | status[1:0], front_value[31:0], back_value[31:0], is_empty, entry_count[4:0]
//
// Refused requests, unused codes and removal of the last entry: handled in the idle state.
// Add: value and new link, then the cursor's link (the first step alone into an empty list);
// unless it fills the store, the next item waits for the free-slot search, which examines
// one slot per cycle. Remove and advance: dependent link RAM read, then value RAM read.
// After reset a clearing pass runs over the used-bit RAM first. Requests stall while a
// result is held in the output register and not taken.
module circular_list_with_cursor_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clwc_req_if.sink   req_i,
  clwc_rsp_if.source rsp_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (DATA_WIDTH > clwc_pkg::VAL_W) ? DATA_WIDTH : clwc_pkg::VAL_W;
  localparam int XCW = (CW > clwc_pkg::CNT_O_W) ? CW : clwc_pkg::CNT_O_W;

  clwc_pkg::seq_state_e state_q, state_d;

  // List state: cursor and its successor, with their values cached
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         nxt_q, nxt_d;
  logic [DATA_WIDTH-1:0] cur_val_q, cur_val_d;
  logic [DATA_WIDTH-1:0] nxt_val_q, nxt_val_d;
  logic                  empty_q, empty_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  is_rem_q, is_rem_d;
  logic [AW-1:0]         new_slot_q, new_slot_d;

  // Output register
  logic                          out_v_q;
  logic [clwc_pkg::ST_W-1:0]     out_status_q;
  logic [clwc_pkg::VAL_W-1:0]    out_front_q, out_back_q;
  logic                          out_empty_q;
  logic [clwc_pkg::CNT_O_W-1:0]  out_count_q;

  logic                      post;
  logic [clwc_pkg::ST_W-1:0] status_d;

  logic in_fire, out_fire, full, alloc_busy;
  logic [XW-1:0]         vin_x;
  logic [DATA_WIDTH-1:0] vin;

  // RAM ports
  logic                  l_we, l_re, v_we, v_re;
  logic [AW-1:0]         l_waddr, l_raddr, v_waddr, v_raddr;
  logic [AW-1:0]         l_wdata, l_rdata;
  logic [DATA_WIDTH-1:0] v_rdata;

  clwc_pkg::alloc_cmd_t alloc_cmd;
  logic [AW-1:0]        rel_slot, low_slot;

  assign vin_x    = XW'(req_i.value_in);
  assign vin      = vin_x[DATA_WIDTH-1:0];
  assign full     = (count_q == CW'(CAPACITY));
  assign out_fire = out_v_q && rsp_o.ready;

  assign req_i.ready = (state_q == clwc_pkg::SEQ_IDLE) && !alloc_busy &&
                       (!out_v_q || rsp_o.ready);
  assign in_fire     = req_i.valid && req_i.ready;

  clwc_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  clwc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (vin),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  clwc_alloc #(
    .CAPACITY (CAPACITY)
  ) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (alloc_cmd),
    .rel_slot_i (rel_slot),
    .low_slot_o (low_slot),
    .busy_o     (alloc_busy)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      clwc_pkg::SEQ_IDLE: begin
        if (in_fire) begin
          case (req_i.req_type)
            clwc_pkg::REQ_ADD: begin
              if (!full && !empty_q) state_d = clwc_pkg::SEQ_ADD2;
            end
            clwc_pkg::REQ_REM: begin
              if (!empty_q && (nxt_q != cur_q)) state_d = clwc_pkg::SEQ_LINK;
            end
            clwc_pkg::REQ_ADV: begin
              if (!empty_q) state_d = clwc_pkg::SEQ_LINK;
            end
            default: ;
          endcase
        end
      end
      clwc_pkg::SEQ_ADD2: state_d = clwc_pkg::SEQ_IDLE;
      clwc_pkg::SEQ_LINK: state_d = clwc_pkg::SEQ_VAL;
      clwc_pkg::SEQ_VAL:  state_d = clwc_pkg::SEQ_IDLE;
      default:            state_d = clwc_pkg::SEQ_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    cur_val_d  = cur_val_q;
    nxt_val_d  = nxt_val_q;
    empty_d    = empty_q;
    count_d    = count_q;
    is_rem_d   = is_rem_q;
    new_slot_d = new_slot_q;
    post       = 1'b0;
    status_d   = clwc_pkg::ST_OK;
    l_we       = 1'b0;
    l_waddr    = cur_q;
    l_wdata    = new_slot_q;
    l_re       = 1'b0;
    l_raddr    = nxt_q;
    v_we       = 1'b0;
    v_waddr    = low_slot;
    v_re       = 1'b0;
    v_raddr    = l_rdata;
    alloc_cmd  = '0;
    rel_slot   = nxt_q;
    case (state_q)
      clwc_pkg::SEQ_IDLE: begin
        if (in_fire) begin
          case (req_i.req_type)
            clwc_pkg::REQ_ADD: begin
              post = 1'b1;
              if (full) begin
                status_d = clwc_pkg::ST_FULL;
              end else begin
                alloc_cmd.take    = 1'b1;
                alloc_cmd.no_scan = (count_q == CW'(CAPACITY - 1));
                v_we    = 1'b1;
                l_we    = 1'b1;
                l_waddr = low_slot;
                l_wdata = empty_q ? low_slot : nxt_q;
                count_d = count_q + 1'b1;
                nxt_d     = low_slot;
                nxt_val_d = vin;
                if (empty_q) begin
                  // sole entry links to itself and holds the cursor
                  cur_d     = low_slot;
                  cur_val_d = vin;
                  empty_d   = 1'b0;
                end else begin
                  new_slot_d = low_slot;
                end
              end
            end
            clwc_pkg::REQ_REM: begin
              if (empty_q) begin
                status_d = clwc_pkg::ST_EMPTY;
                post     = 1'b1;
              end else begin
                alloc_cmd.rel      = 1'b1;
                alloc_cmd.was_full = full;
                count_d = count_q - 1'b1;
                if (nxt_q == cur_q) begin
                  empty_d = 1'b1;
                  post    = 1'b1;
                end else begin
                  l_re     = 1'b1;
                  is_rem_d = 1'b1;
                end
              end
            end
            clwc_pkg::REQ_ADV: begin
              if (empty_q) begin
                status_d = clwc_pkg::ST_EMPTY;
                post     = 1'b1;
              end else begin
                cur_d     = nxt_q;
                cur_val_d = nxt_val_q;
                l_re      = 1'b1;
                is_rem_d  = 1'b0;
              end
            end
            default: post = 1'b1;
          endcase
        end
      end
      clwc_pkg::SEQ_ADD2: begin
        // cursor's link now points at the new entry
        l_we = 1'b1;
      end
      clwc_pkg::SEQ_LINK: begin
        nxt_d = l_rdata;
        v_re  = 1'b1;
        if (is_rem_q) begin
          // unlink the removed entry
          l_we    = 1'b1;
          l_wdata = l_rdata;
        end
      end
      clwc_pkg::SEQ_VAL: begin
        nxt_val_d = v_rdata;
        post      = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clwc_pkg::SEQ_IDLE;
      cur_q   <= '0;
      nxt_q   <= '0;
      empty_q <= 1'b1;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      nxt_q   <= nxt_d;
      empty_q <= empty_d;
      count_q <= count_d;
      if (post) begin
        out_v_q <= 1'b1;
      end else if (out_fire) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [XW-1:0]  front_x, back_x;
  logic [XCW-1:0] count_x;

  assign front_x = XW'(nxt_val_d);
  assign back_x  = XW'(cur_val_d);
  assign count_x = XCW'(count_d);

  always_ff @(posedge clk_i) begin
    cur_val_q  <= cur_val_d;
    nxt_val_q  <= nxt_val_d;
    is_rem_q   <= is_rem_d;
    new_slot_q <= new_slot_d;
    if (post) begin
      out_status_q <= status_d;
      out_front_q  <= empty_d ? '0 : front_x[clwc_pkg::VAL_W-1:0];
      out_back_q   <= empty_d ? '0 : back_x[clwc_pkg::VAL_W-1:0];
      out_empty_q  <= empty_d;
      out_count_q  <= count_x[clwc_pkg::CNT_O_W-1:0];
    end
  end

  assign rsp_o.valid       = out_v_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.entry_count = out_count_q;

  // Assertions
`include "circular_list_with_cursor_top_macros.svh"

  `CLWC_ASSERT(a_count_range, count_q <= CW'(CAPACITY), "entry count above capacity")
  `CLWC_ASSERT(a_empty_count, empty_q == (count_q == '0), "empty flag disagrees with count")
  `CLWC_ASSERT_NEXT(a_adv_walk, in_fire && !empty_q && (req_i.req_type == clwc_pkg::REQ_ADV), state_q == clwc_pkg::SEQ_LINK, "advance did not start link read")
  `CLWC_ASSERT_NEXT(a_add_count, in_fire && !full && (req_i.req_type == clwc_pkg::REQ_ADD), count_q == $past(count_q) + 1'b1, "add did not bump count")

endmodule

>>> rtl/clwc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module clwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/clwc_alloc.sv
`timescale 1ns / 1ps

// Free-slot allocator: one used bit per slot in RAM, a lowest-free pointer,
// a clearing pass after reset and a forward search after each take that leaves a slot free.
module clwc_alloc #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  clwc_pkg::alloc_cmd_t        cmd_i,
  input  logic [$clog2(CAPACITY)-1:0] rel_slot_i,
  output logic [$clog2(CAPACITY)-1:0] low_slot_o,
  output logic                        busy_o
);

  localparam int AW = $clog2(CAPACITY);

  clwc_pkg::alloc_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] low_q, low_d;
  logic [AW-1:0] scan_q, scan_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_slot_q, pend_slot_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [0:0]    wdata, rdata;

  clwc_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      clwc_pkg::ALC_CLEAR: begin
        if (clr_q == AW'(CAPACITY - 1)) state_d = clwc_pkg::ALC_READY;
      end
      clwc_pkg::ALC_READY: begin
        if (cmd_i.take && !cmd_i.no_scan) state_d = clwc_pkg::ALC_SCAN;
      end
      clwc_pkg::ALC_SCAN: begin
        if (pend_q && !rdata[0]) state_d = clwc_pkg::ALC_READY;
      end
      default: state_d = clwc_pkg::ALC_CLEAR;
    endcase
  end

  // RAM control and pointers
  always_comb begin
    we          = 1'b0;
    waddr       = clr_q;
    wdata       = 1'b0;
    re          = 1'b0;
    raddr       = scan_q;
    clr_d       = clr_q;
    low_d       = low_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_slot_d = scan_q;
    case (state_q)
      clwc_pkg::ALC_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      clwc_pkg::ALC_READY: begin
        if (cmd_i.take) begin
          we     = 1'b1;
          waddr  = low_q;
          wdata  = 1'b1;
          // all slots below the taken one are in use
          scan_d = low_q + 1'b1;
        end else if (cmd_i.rel) begin
          we    = 1'b1;
          waddr = rel_slot_i;
          if (cmd_i.was_full || (rel_slot_i < low_q)) low_d = rel_slot_i;
        end
      end
      clwc_pkg::ALC_SCAN: begin
        // one read issued per cycle, result checked in the next cycle
        re     = 1'b1;
        scan_d = scan_q + 1'b1;
        pend_d = 1'b1;
        if (pend_q && !rdata[0]) begin
          low_d  = pend_slot_q;
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clwc_pkg::ALC_CLEAR;
      clr_q   <= '0;
      low_q   <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      low_q   <= low_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
  end

  assign low_slot_o = low_q;
  assign busy_o     = (state_q != clwc_pkg::ALC_READY);

endmodule
